/* src/mlfq_pkg.sv */
// Package of the multilevel feedback queue scheduler: sizes, register
// indexes and the input and result word types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned MAX_LEVELS = 4;
  localparam int unsigned LVL_W      = 2;
  localparam int unsigned QADDR_W    = LVL_W + SLOT_W;
  localparam int unsigned QDEPTH     = MAX_LEVELS * SLOTS;
  localparam int unsigned TICK_W     = 21;
  localparam int unsigned BOOST_W    = 22;
  localparam int unsigned PADDR_W    = 5;

  localparam logic [2:0] REG_NUM_LEVELS = 3'd0;
  localparam logic [2:0] REG_BOOST      = 3'd1;
  localparam logic [2:0] REG_QUANTUM0   = 3'd2;
  localparam logic [2:0] REG_QUANTUM1   = 3'd3;
  localparam logic [2:0] REG_QUANTUM2   = 3'd4;
  localparam logic [2:0] REG_QUANTUM3   = 3'd5;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } in_word_t;

  typedef struct packed {
    logic              all_done;
    logic [TICK_W-1:0] slice_start;
    logic [7:0]        slice_proc;
    logic [15:0]       slice_length;
    logic              finished;
    logic [TICK_W-1:0] completion;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] waiting;
    logic [TICK_W-1:0] response;
  } out_word_t;

endpackage
`default_nettype wire

/* src/mlfq_if.sv */
// Valid/ready channel interfaces for the input and result words.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mlfq_in_if;
  logic              valid;
  logic              ready;
  mlfq_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlfq_out_if;
  logic               valid;
  logic               ready;
  mlfq_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/multilevel_feedback_queue_scheduler.sv */
// Top level of the multilevel feedback queue scheduler: process stores, level
// rings in a small memory, and the sequencer. Depends on mlfq_pkg, mlfq_if.
`timescale 1ns / 1ps
`default_nettype none
// A load word is taken and gives no result. A dispatch word runs a sequencer
// that walks the process slots one per cycle with a single compare unit: the
// first dispatch scans loaded slots for tick-0 arrivals, a boost moves each
// lower-level entry to level 0 (ring memory read, then write), an idle jump
// costs two more scans, and the arrival scan after each slice costs one scan.
// The block is not ready while a dispatch is at work or its result word waits.
module multilevel_feedback_queue_scheduler (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  mlfq_in_if.sink                         in_s,
  mlfq_out_if.source                      out_m,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mlfq_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_INIT     = 14'b00000000000010,
    S_BOOST    = 14'b00000000000100,
    S_DRAIN    = 14'b00000000001000,
    S_DRAIN_WR = 14'b00000000010000,
    S_FIND     = 14'b00000000100000,
    S_MIN      = 14'b00000001000000,
    S_JUMP     = 14'b00000010000000,
    S_POP      = 14'b00000100000000,
    S_RUN      = 14'b00001000000000,
    S_ARR      = 14'b00010000000000,
    S_FIN      = 14'b00100000000000,
    S_WAIT     = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_e;

  localparam int unsigned SW = mlfq_pkg::SLOT_W;
  localparam int unsigned CW = mlfq_pkg::CNT_W;
  localparam int unsigned LW = mlfq_pkg::LVL_W;
  localparam int unsigned TW = mlfq_pkg::TICK_W;
  localparam int unsigned BW = mlfq_pkg::BOOST_W;

  // Configuration registers.
  logic [2:0]  num_levels_q;
  logic [19:0] boost_q;
  logic [15:0] quantum_q [mlfq_pkg::MAX_LEVELS];

  // Process stores.
  logic [15:0]   arr_q [mlfq_pkg::SLOTS];
  logic [15:0]   bst_q [mlfq_pkg::SLOTS];
  logic [15:0]   rem_q [mlfq_pkg::SLOTS];
  logic [7:0]    id_q  [mlfq_pkg::SLOTS];
  logic [TW-1:0] fst_q [mlfq_pkg::SLOTS];
  logic [mlfq_pkg::SLOTS-1:0] started_q, fin_q;

  // Level rings.
  logic [SW-1:0] qmem [mlfq_pkg::QDEPTH];
  logic [SW-1:0] qrd_q;
  logic [SW-1:0] head_q [mlfq_pkg::MAX_LEVELS];
  logic [SW-1:0] head_d [mlfq_pkg::MAX_LEVELS];
  logic [CW-1:0] cnt_q  [mlfq_pkg::MAX_LEVELS];
  logic [CW-1:0] cnt_d  [mlfq_pkg::MAX_LEVELS];

  state_e        state_q, state_d;
  logic [TW-1:0] now_q, now_d;
  logic [BW-1:0] nbt_q, nbt_d;
  logic [CW-1:0] loaded_q, loaded_d, fcount_q, fcount_d, idx_q, idx_d;
  logic          running_q, running_d, pass_q, pass_d, any_q, any_d;
  logic [2:0]    lscan_q, lscan_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [15:0]   best_q, best_d, run_q, run_d, quant_q, quant_d;
  logic [TW-1:0] start_q, start_d, turn_q, turn_d;
  mlfq_pkg::out_word_t res_q, res_d;
  logic          ovalid_q, ovalid_d;

  // Single push and pop port of the rings.
  logic          push_en, pop_en, q_we, full;
  logic [LW-1:0] push_lvl, pop_lvl, found_lvl;
  logic [SW-1:0] push_slot, push_pos;
  logic          found;

  logic [SW-1:0] rd_idx;
  logic [15:0]   a_rd, b_rd, r_rd;
  logic [7:0]    i_rd;
  logic [TW-1:0] f_rd;
  logic [2:0]    eff;
  logic [15:0]   qsel, qeff, run_c;
  logic          scan_end, in_acc, cfg_wr, load_ok;
  logic [BW:0]   nbt_sum;
  logic [BW-1:0] end22;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_acc  = in_s.valid && in_s.ready;
  assign in_s.ready  = (state_q == S_IDLE);
  assign out_m.valid = ovalid_q;
  assign out_m.data  = res_q;

  always_comb begin
    case (paddr[4:2])
      mlfq_pkg::REG_NUM_LEVELS: prdata = {29'd0, num_levels_q};
      mlfq_pkg::REG_BOOST:      prdata = {12'd0, boost_q};
      mlfq_pkg::REG_QUANTUM0:   prdata = {16'd0, quantum_q[0]};
      mlfq_pkg::REG_QUANTUM1:   prdata = {16'd0, quantum_q[1]};
      mlfq_pkg::REG_QUANTUM2:   prdata = {16'd0, quantum_q[2]};
      mlfq_pkg::REG_QUANTUM3:   prdata = {16'd0, quantum_q[3]};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= 3'd3;
      boost_q      <= 20'd0;
      quantum_q[0] <= 16'd1;
      quantum_q[1] <= 16'd2;
      quantum_q[2] <= 16'd4;
      quantum_q[3] <= 16'd8;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        mlfq_pkg::REG_NUM_LEVELS: num_levels_q <= pwdata[2:0];
        mlfq_pkg::REG_BOOST:      boost_q      <= pwdata[19:0];
        mlfq_pkg::REG_QUANTUM0:   quantum_q[0] <= pwdata[15:0];
        mlfq_pkg::REG_QUANTUM1:   quantum_q[1] <= pwdata[15:0];
        mlfq_pkg::REG_QUANTUM2:   quantum_q[2] <= pwdata[15:0];
        mlfq_pkg::REG_QUANTUM3:   quantum_q[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Scans address the stores by the slot counter, the slice states by the
  // slot taken from the ring.
  assign rd_idx = (state_q == S_RUN || state_q == S_FIN || state_q == S_WAIT) ?
                  slot_q : idx_q[SW-1:0];
  assign a_rd = arr_q[rd_idx];
  assign b_rd = bst_q[rd_idx];
  assign r_rd = rem_q[rd_idx];
  assign i_rd = id_q[rd_idx];
  assign f_rd = fst_q[rd_idx];
  assign scan_end = (idx_q >= loaded_q);

  assign eff = (num_levels_q > 3'(mlfq_pkg::MAX_LEVELS)) ?
               3'(mlfq_pkg::MAX_LEVELS) : num_levels_q;
  assign qsel  = quantum_q[lvl_q];
  assign qeff  = (qsel == 16'd0) ? 16'd1 : qsel;
  assign run_c = (r_rd < qeff) ? r_rd : qeff;
  assign nbt_sum = {1'b0, nbt_q} + {3'd0, boost_q};
  assign end22 = {1'b0, start_q} + {6'd0, run_q};
  assign load_ok = !running_q && (loaded_q < CW'(mlfq_pkg::SLOTS));

  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int l = mlfq_pkg::MAX_LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        found     = 1'b1;
        found_lvl = LW'(l);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    nbt_d     = nbt_q;
    loaded_d  = loaded_q;
    fcount_d  = fcount_q;
    idx_d     = idx_q;
    running_d = running_q;
    pass_d    = pass_q;
    any_d     = any_q;
    lscan_d   = lscan_q;
    lvl_d     = lvl_q;
    slot_d    = slot_q;
    best_d    = best_q;
    run_d     = run_q;
    quant_d   = quant_q;
    start_d   = start_q;
    turn_d    = turn_q;
    res_d     = res_q;
    ovalid_d  = ovalid_q;
    push_en   = 1'b0;
    push_lvl  = '0;
    push_slot = idx_q[SW-1:0];
    pop_en    = 1'b0;
    pop_lvl   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_s.data.func == mlfq_pkg::FUNC_LOAD) begin
            if (load_ok) loaded_d = loaded_q + CW'(1);
          end else if (eff == 3'd0 || fcount_q >= loaded_q) begin
            res_d = '0;
            res_d.all_done = 1'b1;
            ovalid_d = 1'b1;
            state_d  = S_OUT;
          end else if (!running_q) begin
            running_d = 1'b1;
            now_d     = '0;
            nbt_d     = (boost_q != 20'd0) ? {2'd0, boost_q} : '1;
            idx_d     = '0;
            pass_d    = 1'b0;
            state_d   = S_INIT;
          end else begin
            pass_d  = 1'b0;
            state_d = S_BOOST;
          end
        end
      end
      S_INIT: begin
        if (scan_end) begin
          state_d = S_BOOST;
        end else begin
          push_en = (a_rd == 16'd0);
          idx_d   = idx_q + CW'(1);
        end
      end
      S_BOOST: begin
        if ({1'b0, now_q} >= nbt_q) begin
          lscan_d = 3'd1;
          state_d = S_DRAIN;
        end else begin
          state_d = S_FIND;
        end
      end
      S_DRAIN: begin
        if (lscan_q >= 3'(mlfq_pkg::MAX_LEVELS)) begin
          nbt_d   = nbt_sum[BW] ? '1 : nbt_sum[BW-1:0];
          state_d = S_FIND;
        end else if (cnt_q[lscan_q[LW-1:0]] == '0) begin
          lscan_d = lscan_q + 3'd1;
        end else begin
          pop_en  = 1'b1;
          pop_lvl = lscan_q[LW-1:0];
          state_d = S_DRAIN_WR;
        end
      end
      S_DRAIN_WR: begin
        push_en   = 1'b1;
        push_slot = qrd_q;
        state_d   = S_DRAIN;
      end
      S_FIND: begin
        if (found) begin
          lvl_d   = found_lvl;
          pop_en  = 1'b1;
          pop_lvl = found_lvl;
          state_d = S_POP;
        end else if (pass_q) begin
          res_d = '0;
          res_d.all_done = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_OUT;
        end else begin
          idx_d   = '0;
          any_d   = 1'b0;
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (scan_end) begin
          if (!any_q) begin
            res_d = '0;
            res_d.all_done = 1'b1;
            ovalid_d = 1'b1;
            state_d  = S_OUT;
          end else begin
            now_d   = {5'd0, best_q};
            idx_d   = '0;
            state_d = S_JUMP;
          end
        end else begin
          if (!fin_q[idx_q[SW-1:0]] && {5'd0, a_rd} > now_q &&
              (!any_q || a_rd < best_q)) begin
            best_d = a_rd;
            any_d  = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
      end
      S_JUMP: begin
        if (scan_end) begin
          pass_d  = 1'b1;
          state_d = S_BOOST;
        end else begin
          push_en = ({5'd0, a_rd} == now_q);
          idx_d   = idx_q + CW'(1);
        end
      end
      S_POP: begin
        slot_d  = qrd_q;
        state_d = S_RUN;
      end
      S_RUN: begin
        start_d = now_q;
        run_d   = run_c;
        quant_d = qeff;
        now_d   = now_q + TW'(run_c);
        idx_d   = '0;
        state_d = S_ARR;
      end
      S_ARR: begin
        if (scan_end) begin
          state_d = S_FIN;
        end else begin
          push_en = !fin_q[idx_q[SW-1:0]] && {6'd0, a_rd} > {1'b0, start_q} &&
                    {6'd0, a_rd} <= end22;
          idx_d   = idx_q + CW'(1);
        end
      end
      S_FIN: begin
        res_d = '0;
        res_d.slice_start  = start_q;
        res_d.slice_proc   = i_rd;
        res_d.slice_length = run_q;
        if (r_rd == 16'd0) begin
          res_d.finished   = 1'b1;
          res_d.completion = now_q;
          res_d.response   = f_rd - {5'd0, a_rd};
          turn_d   = now_q - {5'd0, a_rd};
          fcount_d = fcount_q + CW'(1);
          state_d  = S_WAIT;
        end else begin
          push_en   = 1'b1;
          push_slot = slot_q;
          if (run_q == quant_q && ({1'b0, lvl_q} + 3'd1) < eff) begin
            push_lvl = lvl_q + LW'(1);
          end else begin
            push_lvl = lvl_q;
          end
          ovalid_d = 1'b1;
          state_d  = S_OUT;
        end
      end
      S_WAIT: begin
        res_d.turnaround = turn_q;
        res_d.waiting    = turn_q - {5'd0, b_rd};
        ovalid_d = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_m.ready) begin
          ovalid_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Ring bookkeeping for the single push and pop of this cycle.
  assign push_pos = head_q[push_lvl] + cnt_q[push_lvl][SW-1:0];
  assign full     = (cnt_q[push_lvl] == CW'(mlfq_pkg::SLOTS));
  assign q_we     = push_en && !full;

  always_comb begin
    for (int l = 0; l < mlfq_pkg::MAX_LEVELS; l++) begin
      head_d[l] = head_q[l];
      cnt_d[l]  = cnt_q[l];
      if (q_we && push_lvl == LW'(l)) cnt_d[l] = cnt_q[l] + CW'(1);
      if (pop_en && pop_lvl == LW'(l)) begin
        head_d[l] = head_q[l] + SW'(1);
        cnt_d[l]  = cnt_q[l] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[{push_lvl, push_pos}] <= push_slot;
    if (pop_en) qrd_q <= qmem[{pop_lvl, head_q[pop_lvl]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      nbt_q     <= '1;
      loaded_q  <= '0;
      fcount_q  <= '0;
      idx_q     <= '0;
      running_q <= 1'b0;
      pass_q    <= 1'b0;
      any_q     <= 1'b0;
      lscan_q   <= '0;
      lvl_q     <= '0;
      slot_q    <= '0;
      ovalid_q  <= 1'b0;
      started_q <= '0;
      fin_q     <= '0;
      for (int l = 0; l < mlfq_pkg::MAX_LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      nbt_q     <= nbt_d;
      loaded_q  <= loaded_d;
      fcount_q  <= fcount_d;
      idx_q     <= idx_d;
      running_q <= running_d;
      pass_q    <= pass_d;
      any_q     <= any_d;
      lscan_q   <= lscan_d;
      lvl_q     <= lvl_d;
      slot_q    <= slot_d;
      ovalid_q  <= ovalid_d;
      for (int l = 0; l < mlfq_pkg::MAX_LEVELS; l++) begin
        head_q[l] <= head_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
      if (state_q == S_IDLE && in_acc && in_s.data.func == mlfq_pkg::FUNC_LOAD &&
          load_ok) begin
        started_q[loaded_q[SW-1:0]] <= 1'b0;
        fin_q[loaded_q[SW-1:0]]     <= 1'b0;
      end
      if (state_q == S_RUN) started_q[slot_q] <= 1'b1;
      if (state_q == S_FIN && r_rd == 16'd0) fin_q[slot_q] <= 1'b1;
    end
  end

  // Store payload and slice working registers.
  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    run_q   <= run_d;
    quant_q <= quant_d;
    start_q <= start_d;
    turn_q  <= turn_d;
    res_q   <= res_d;
    if (state_q == S_IDLE && in_acc && in_s.data.func == mlfq_pkg::FUNC_LOAD &&
        load_ok) begin
      id_q[loaded_q[SW-1:0]]  <= in_s.data.proc_id;
      arr_q[loaded_q[SW-1:0]] <= in_s.data.arrival;
      bst_q[loaded_q[SW-1:0]] <= in_s.data.burst;
      rem_q[loaded_q[SW-1:0]] <= in_s.data.burst;
    end
    if (state_q == S_RUN) begin
      rem_q[slot_q] <= r_rd - run_c;
      if (!started_q[slot_q]) fst_q[slot_q] <= now_q;
    end
  end

  logic [CW+1:0] queued_sum;
  assign queued_sum = (CW+2)'(cnt_q[0]) + (CW+2)'(cnt_q[1]) +
                      (CW+2)'(cnt_q[2]) + (CW+2)'(cnt_q[3]);

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid |-> !in_s.ready)
    else $error("input ready while a result word waits");

  a_fin_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= loaded_q)
    else $error("more finished processes than loaded ones");

  a_queued_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_sum <= (CW+2)'(loaded_q))
    else $error("level rings hold more entries than loaded processes");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_m.valid && out_m.data.all_done) |->
      (!out_m.data.finished && out_m.data.slice_length == 16'd0))
    else $error("all-done word carries slice data");

endmodule
`default_nettype wire
